>>> rtl/clock_24h_with_set_buttons_unit_macros.svh
// Assertion macros for the 24-hour clock unit.
`ifndef CLOCK_24H_WITH_SET_BUTTONS_UNIT_MACROS_SVH
`define CLOCK_24H_WITH_SET_BUTTONS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define CLK24_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("clk24 invariant failed");

`define CLK24_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clk24 sequence check failed");

`else

`define CLK24_ASSERT(lbl, cond)

`define CLK24_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/clk24_pkg.sv
// Types, constants and decode functions shared by the 24-hour clock unit.
`timescale 1ns / 1ps

package clk24_pkg;

  localparam int BTN_W = 4;
  localparam int SOD_W = 17;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_PRESS = 1'b1;

  localparam logic [BTN_W-1:0] BTN_MIN_UP   = 4'b0001;
  localparam logic [BTN_W-1:0] BTN_MIN_DOWN = 4'b0010;
  localparam logic [BTN_W-1:0] BTN_HOUR_UP  = 4'b0100;
  localparam logic [BTN_W-1:0] BTN_HOUR_DN  = 4'b1000;

  localparam logic [4:0] LAST_HOUR = 5'd23;
  localparam logic [5:0] LAST_MIN  = 6'd59;
  localparam logic [5:0] LAST_SEC  = 6'd59;

  localparam logic [SOD_W-1:0] SEC_PER_MIN  = 17'd60;
  localparam logic [SOD_W-1:0] SEC_PER_HOUR = 17'd3600;

  localparam logic [7:0] SEG_A = 8'h80;
  localparam logic [7:0] SEG_B = 8'h40;
  localparam logic [7:0] SEG_C = 8'h20;
  localparam logic [7:0] SEG_D = 8'h10;
  localparam logic [7:0] SEG_E = 8'h08;
  localparam logic [7:0] SEG_F = 8'h04;
  localparam logic [7:0] SEG_G = 8'h02;

  // Time of day in mixed radix plus the half-second phase.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       phase;
  } tod_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Packed so that the first field sits in the highest bits.
  typedef struct packed {
    logic [SOD_W-1:0] second_of_day;
    logic             dots_level;
    logic [7:0]       seg_minute_ones;
    logic [7:0]       seg_minute_tens;
    logic [7:0]       seg_hour_ones;
    logic [7:0]       seg_hour_tens;
    logic [3:0]       minute_ones;
    logic [2:0]       minute_tens;
    logic [3:0]       hour_ones;
    logic [1:0]       hour_tens;
  } result_t;

  function automatic digits_t dec_split(input logic [5:0] v);
    digits_t    d;
    logic [5:0] rem;
    if (v >= 6'd50) begin
      d.tens = 3'd5;
    end else if (v >= 6'd40) begin
      d.tens = 3'd4;
    end else if (v >= 6'd30) begin
      d.tens = 3'd3;
    end else if (v >= 6'd20) begin
      d.tens = 3'd2;
    end else if (v >= 6'd10) begin
      d.tens = 3'd1;
    end else begin
      d.tens = 3'd0;
    end
    rem    = v - 6'({3'b000, d.tens} * 6'd10);
    d.ones = rem[3:0];
    return d;
  endfunction

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1:    s = SEG_B | SEG_C;
      4'd2:    s = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
      4'd3:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      4'd4:    s = SEG_B | SEG_C | SEG_F | SEG_G;
      4'd5:    s = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
      4'd6:    s = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd7:    s = SEG_A | SEG_B | SEG_C;
      4'd8:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd9:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/clock_24h_with_set_buttons_unit.sv
// Top level of the 24-hour clock unit with set buttons.
//
//   channel | ports      | tdata / tuser
//   --------+------------+---------------------------------------------------
//   input   | in_t*      | tuser: req_type; tdata: buttons[3:0], zero fill
//   result  | out_t*     | tdata: digits, segment patterns, dots, second_of_day
//
// An accepted transfer sits in the input register, and the cycle it moves on
// updates the time register, loads the result register and sets out_tvalid.
// A new item is taken every cycle while the result side keeps up. A stalled
// result holds the input register, and a full input register stalls the input
// side.
// rst_n synchronously clears the time to 00:00:00, phase even, and both valids.
`timescale 1ns / 1ps
`include "clock_24h_with_set_buttons_unit_macros.svh"

module clock_24h_with_set_buttons_unit import clk24_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] buttons, [7:4] zero
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [1:0] hour_tens, [5:2] hour_ones,
                                  // [8:6] minute_tens, [12:9] minute_ones,
                                  // [20:13] seg_hour_tens, [28:21] seg_hour_ones,
                                  // [36:29] seg_minute_tens,
                                  // [44:37] seg_minute_ones, [45] dots_level,
                                  // [62:46] second_of_day, [63] zero
);

  logic             in_valid_r;
  logic             in_type_r;
  logic [BTN_W-1:0] in_btn_r;
  logic             out_valid_r;
  result_t          res_r;
  result_t          res_nxt;
  tod_t             tod_nxt;
  tod_t             tod_cur;
  logic             adv;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  clk24_time u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (adv),
    .req_type (in_type_r),
    .buttons  (in_btn_r),
    .tod_nxt  (tod_nxt),
    .tod_cur  (tod_cur)
  );

  clk24_disp u_disp (
    .tod (tod_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_type_r <= in_tuser;
      in_btn_r  <= in_tdata[BTN_W-1:0];
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  `CLK24_ASSERT(a_time_range, (tod_cur.hour <= LAST_HOUR) && (tod_cur.minute <= LAST_MIN) && (tod_cur.second <= LAST_SEC))
  `CLK24_ASSERT_NEXT(a_button_cuts_seconds, adv && in_type_r && (in_btn_r != '0), tod_cur.second == '0)
  `CLK24_ASSERT_NEXT(a_tick_flips_phase, adv && !in_type_r, tod_cur.phase != $past(tod_cur.phase))
  `CLK24_ASSERT(a_stall_blocks_input, !(out_valid_r && !out_tready && in_valid_r && in_tready))

endmodule

>>> rtl/clk24_time.sv
// Time-of-day state register with tick and set-button update logic.
`timescale 1ns / 1ps

module clk24_time import clk24_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             upd_en,
  input  logic             req_type,
  input  logic [BTN_W-1:0] buttons,
  output tod_t             tod_nxt,
  output tod_t             tod_cur
);

  tod_t tod_r;

  always_comb begin
    tod_nxt = tod_r;
    if (req_type == REQ_TICK) begin
      tod_nxt.phase = ~tod_r.phase;
      if (tod_r.phase) begin
        if (tod_r.second == LAST_SEC) begin
          tod_nxt.second = '0;
          if (tod_r.minute == LAST_MIN) begin
            tod_nxt.minute = '0;
            tod_nxt.hour   = (tod_r.hour == LAST_HOUR) ? '0 : tod_r.hour + 5'd1;
          end else begin
            tod_nxt.minute = tod_r.minute + 6'd1;
          end
        end else begin
          tod_nxt.second = tod_r.second + 6'd1;
        end
      end
    end else if (buttons != '0) begin
      case (buttons)
        BTN_MIN_UP: begin
          if (tod_r.minute == LAST_MIN) begin
            tod_nxt.minute = '0;
            tod_nxt.hour   = (tod_r.hour == LAST_HOUR) ? '0 : tod_r.hour + 5'd1;
          end else begin
            tod_nxt.minute = tod_r.minute + 6'd1;
          end
        end
        BTN_MIN_DOWN: begin
          if (tod_r.minute == '0) begin
            tod_nxt.minute = LAST_MIN;
            tod_nxt.hour   = (tod_r.hour == '0) ? LAST_HOUR : tod_r.hour - 5'd1;
          end else begin
            tod_nxt.minute = tod_r.minute - 6'd1;
          end
        end
        BTN_HOUR_UP: begin
          // Past midnight the whole time drops to 00:00.
          if (tod_r.hour == LAST_HOUR) begin
            tod_nxt.hour   = '0;
            tod_nxt.minute = '0;
          end else begin
            tod_nxt.hour = tod_r.hour + 5'd1;
          end
        end
        BTN_HOUR_DN: begin
          // Below midnight lands on 23:00 sharp.
          if (tod_r.hour == '0) begin
            tod_nxt.hour   = LAST_HOUR;
            tod_nxt.minute = '0;
          end else begin
            tod_nxt.hour = tod_r.hour - 5'd1;
          end
        end
        default: begin
        end
      endcase
      tod_nxt.second = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r <= '0;
    end else if (upd_en) begin
      tod_r <= tod_nxt;
    end
  end

  assign tod_cur = tod_r;

endmodule

>>> rtl/clk24_disp.sv
// Display decode: digits, segment patterns, dot level and second of day.
`timescale 1ns / 1ps

module clk24_disp import clk24_pkg::*; (
  input  tod_t    tod,
  output result_t res
);

  digits_t          hd;
  digits_t          md;
  logic [SOD_W-1:0] sod;

  always_comb begin
    hd  = dec_split({1'b0, tod.hour});
    md  = dec_split(tod.minute);
    sod = SOD_W'(tod.hour) * SEC_PER_HOUR + SOD_W'(tod.minute) * SEC_PER_MIN
        + SOD_W'(tod.second);
  end

  always_comb begin
    res.hour_tens       = hd.tens[1:0];
    res.hour_ones       = hd.ones;
    res.minute_tens     = md.tens;
    res.minute_ones     = md.ones;
    res.seg_hour_tens   = seg_of({2'b00, hd.tens[1:0]});
    res.seg_hour_ones   = seg_of(hd.ones);
    res.seg_minute_tens = seg_of({1'b0, md.tens});
    res.seg_minute_ones = seg_of(md.ones);
    res.dots_level      = ~tod.phase;
    res.second_of_day   = sod;
  end

endmodule

>>> sim/clk24_readout_checker.sv
// Checker for the 24-hour clock unit: predicts each readout and compares it.
`timescale 1ns / 1ps

module clk24_readout_checker import clk24_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  output int          mismatch_count,
  output int          pending,
  output int          checked_count
);

  localparam int   DAY_SEC  = 86400;
  localparam int   MAX_SHOWN = 10;

  logic [SOD_W-1:0] sod_q;
  logic             phase_q;
  result_t          readouts_due[$];
  result_t          got;
  result_t          want;

  function automatic logic [7:0] seg_pattern(input int digit);
    case (digit)
      0:       return 8'hFC;
      1:       return 8'h60;
      2:       return 8'hDA;
      3:       return 8'hF2;
      4:       return 8'h66;
      5:       return 8'hB6;
      6:       return 8'hBE;
      7:       return 8'hE0;
      8:       return 8'hFE;
      9:       return 8'hF6;
      default: return 8'h00;
    endcase
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("%0d%0d:%0d%0d segs %h %h %h %h dots %b sec %0d",
                     r.hour_tens, r.hour_ones, r.minute_tens, r.minute_ones,
                     r.seg_hour_tens, r.seg_hour_ones, r.seg_minute_tens,
                     r.seg_minute_ones, r.dots_level, r.second_of_day);
  endfunction

  // Updates the time of day for one transfer and queues the readout it gives.
  task automatic advance_clock(input logic kind, input logic [3:0] mask);
    int      s;
    int      mins;
    int      hh;
    int      mm;
    result_t r;
    s = int'(sod_q);
    if (kind == REQ_TICK) begin
      phase_q = ~phase_q;
      if (!phase_q) s = s + 1;
      if (s >= DAY_SEC) s = 0;
    end else if (mask != '0) begin
      case (mask)
        BTN_MIN_UP:   s = s + int'(SEC_PER_MIN);
        BTN_MIN_DOWN: s = (s >= int'(SEC_PER_MIN)) ? s - int'(SEC_PER_MIN)
                                                  : DAY_SEC - int'(SEC_PER_MIN);
        BTN_HOUR_UP:  s = s + int'(SEC_PER_HOUR);
        BTN_HOUR_DN:  s = (s >= int'(SEC_PER_HOUR)) ? s - int'(SEC_PER_HOUR)
                                                   : DAY_SEC - int'(SEC_PER_HOUR);
        default:      ;
      endcase
      if (s >= DAY_SEC) s = 0;
      // any pressed mask drops the seconds
      s = (s / int'(SEC_PER_MIN)) * int'(SEC_PER_MIN);
    end
    sod_q = s[SOD_W-1:0];

    mins = s / 60;
    hh   = mins / 60;
    mm   = mins % 60;
    r.hour_tens       = 2'(hh / 10);
    r.hour_ones       = 4'(hh % 10);
    r.minute_tens     = 3'(mm / 10);
    r.minute_ones     = 4'(mm % 10);
    r.seg_hour_tens   = seg_pattern(hh / 10);
    r.seg_hour_ones   = seg_pattern(hh % 10);
    r.seg_minute_tens = seg_pattern(mm / 10);
    r.seg_minute_ones = seg_pattern(mm % 10);
    r.dots_level      = ~phase_q;
    r.second_of_day   = sod_q;
    readouts_due.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sod_q          = '0;
      phase_q        = 1'b0;
      mismatch_count = 0;
      checked_count  = 0;
      readouts_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (readouts_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("%0t: readout with none pending: %s", $time, show(got));
        end else begin
          want = readouts_due.pop_front();
          checked_count++;
          if (got.hour_tens !== want.hour_tens ||
              got.hour_ones !== want.hour_ones ||
              got.minute_tens !== want.minute_tens ||
              got.minute_ones !== want.minute_ones ||
              got.seg_hour_tens !== want.seg_hour_tens ||
              got.seg_hour_ones !== want.seg_hour_ones ||
              got.seg_minute_tens !== want.seg_minute_tens ||
              got.seg_minute_ones !== want.seg_minute_ones ||
              got.dots_level !== want.dots_level ||
              got.second_of_day !== want.second_of_day) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
              $display("%0t: readout mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (in_tvalid && in_tready) advance_clock(in_tuser, in_tdata[3:0]);
    end
    pending = readouts_due.size();
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the 24-hour clock unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
  import clk24_pkg::*;

  localparam logic [3:0] NO_BUTTONS  = 4'b0000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_ITEMS = 86;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  int mismatch_count;
  int pending;
  int checked_count;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int items_sent = 0;
  int tick_count = 0;
  int press_count = 0;
  bit hold_off_req = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  clock_24h_with_set_buttons_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  clk24_readout_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .checked_count  (checked_count)
  );

  // Offers one item and returns at the edge of its transfer; valid stays up.
  task automatic send_item(input logic kind, input logic [3:0] btn);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, btn};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (kind == REQ_TICK) tick_count++;
    else press_count++;
  endtask

  // Stops offering and waits until every readout is back.
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int roll;
    int phase_target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: wraps both ways, empty and multi-button masks, truncation
    send_item(REQ_TICK, NO_BUTTONS);
    send_item(REQ_TICK, NO_BUTTONS);
    send_item(REQ_PRESS, NO_BUTTONS);
    send_item(REQ_PRESS, BTN_MIN_DOWN);
    send_item(REQ_PRESS, BTN_MIN_UP);
    send_item(REQ_PRESS, BTN_HOUR_DN);
    send_item(REQ_PRESS, BTN_HOUR_UP);
    send_item(REQ_PRESS, BTN_HOUR_UP);
    send_item(REQ_PRESS, BTN_MIN_UP);
    send_item(REQ_TICK, NO_BUTTONS);
    send_item(REQ_TICK, NO_BUTTONS);
    send_item(REQ_PRESS, BTN_MIN_UP | BTN_MIN_DOWN | BTN_HOUR_UP | BTN_HOUR_DN);
    send_item(REQ_TICK, NO_BUTTONS);
    send_item(REQ_TICK, NO_BUTTONS);
    send_item(REQ_PRESS, BTN_MIN_UP | BTN_MIN_DOWN);
    send_item(REQ_PRESS, BTN_HOUR_DN);
    send_item(REQ_PRESS, BTN_MIN_DOWN);
    send_item(REQ_PRESS, BTN_MIN_DOWN);
    send_item(REQ_PRESS, BTN_HOUR_UP | BTN_HOUR_DN);
    send_item(REQ_PRESS, BTN_MIN_UP | BTN_HOUR_UP);
    // now at 23:59:00, ticks carry it through midnight
    repeat (124) send_item(REQ_TICK, 4'($urandom_range(15)));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 34 : (phase == 1) ? 86 : 0;
      sink_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 34 : 0;
      if (phase == 2) hold_off_req = 1'b1;
      phase_target = items_sent + PHASE_ITEMS;
      while (items_sent < phase_target) begin
        roll = $urandom_range(9);
        if (roll < 5) begin
          repeat ($urandom_range(1, 6)) send_item(REQ_TICK, 4'($urandom_range(15)));
        end else if (roll < 8) begin
          send_item(REQ_PRESS, 4'(1 << $urandom_range(3)));
        end else begin
          send_item(REQ_PRESS, 4'($urandom_range(15)));
        end
      end
      drain();
    end

    repeat (6) @(posedge clk);
    $display("run covered %0d items: %0d ticks, %0d button events; %0d readouts checked",
             items_sent, tick_count, press_count, checked_count);
    $display("included day wraps by tick and by button, and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
